FILE: sv/lnp_pkg.sv
// ----------------------------------------------------------------------------
// lnp_pkg
// Shared types, constants and helpers for the linked list node pool.
// ----------------------------------------------------------------------------
package lnp_pkg;

   localparam int POOL_DEPTH = 16;
   localparam int ADDR_W     = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int LINK_W     = ADDR_W + 1;
   localparam int IDX_W      = 5;

   typedef logic [ADDR_W-1:0]        addr_type;
   typedef logic signed [LINK_W-1:0] link_type;
   typedef logic signed [IDX_W-1:0]  idx_type;

   localparam link_type NIL_LINK = '1;

   localparam logic [2:0] MODE_INIT   = 3'd0;
   localparam logic [2:0] MODE_PUSH   = 3'd1;
   localparam logic [2:0] MODE_INSERT = 3'd2;
   localparam logic [2:0] MODE_ERASE  = 3'd3;
   localparam logic [2:0] MODE_READ   = 3'd4;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_NO_SUCC = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SWEEP,
      S_SENT,
      S_ALLOC,
      S_INS_A,
      S_INS_B,
      S_ER_A,
      S_ER_B,
      S_ER_C,
      S_FETCH
   } lnp_state_type;

   typedef struct packed {
      logic        link_we;
      logic        pay_we;
      addr_type    addr;
      link_type    link;
      logic [7:0]  slot;
      logic [31:0] tick;
   } lnp_wr_type;

   function automatic idx_type to_idx(input link_type l);
      logic signed [31:0] w;
      w = 32'(l);
      return w[IDX_W-1:0];
   endfunction

endpackage

FILE: sv/lnp_store.sv
// ----------------------------------------------------------------------------
// lnp_store
// Node storage: next links and payloads, one read and one write per cycle.
// ----------------------------------------------------------------------------
module lnp_store
   import lnp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  addr_type    rd_addr,
   output link_type    rd_link,
   output logic [7:0]  rd_slot,
   output logic [31:0] rd_tick,
   input  lnp_wr_type  wr
);

   link_type    links_ff [POOL_DEPTH];
   logic [7:0]  slots_ff [POOL_DEPTH];
   logic [31:0] ticks_ff [POOL_DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < POOL_DEPTH; i++) begin
            if (i == 0 || i == POOL_DEPTH - 1) begin
               links_ff[i] <= NIL_LINK;
            end else begin
               links_ff[i] <= LINK_W'(i + 1);
            end
            slots_ff[i] <= '0;
            ticks_ff[i] <= '0;
         end
      end else begin
         if (wr.link_we) begin
            links_ff[wr.addr] <= wr.link;
         end
         if (wr.pay_we) begin
            slots_ff[wr.addr] <= wr.slot;
            ticks_ff[wr.addr] <= wr.tick;
         end
      end
   end

   assign rd_link = links_ff[rd_addr];
   assign rd_slot = slots_ff[rd_addr];
   assign rd_tick = ticks_ff[rd_addr];

endmodule

FILE: sv/linked_list_node_pool_top.sv
// ----------------------------------------------------------------------------
// linked_list_node_pool_top
// Node pool with one singly linked list and a free chain.
//
// The req_ channel carries one operation per transaction: reinitialise, push
// front, insert after node, erase after node, or read node. Every transaction
// returns exactly one rsp_ transaction with status, the touched node and its
// link and payload, and the list and free heads after the operation.
// Operations run one at a time through a small sequencer around one read
// port and one write port on the node store; req_ready is high only while
// idle. A read, ignored op or full pool goes straight to the fetch state;
// push allocates, then fetches; insert allocates, links the new node, relinks
// the given node, then fetches; erase reads the successor, relinks around it,
// frees it, then fetches (straight after the read when there is none);
// reinitialise writes one link per node, then the sentinel, then fetches.
// The result sits in an output register, so a new transaction is taken while
// it waits; a stalled receiver holds the next result in the final step until
// the register frees.
// Synchronous reset restores the free chain with node 0 as the sentinel
// head and clears all payloads.
// ----------------------------------------------------------------------------
module linked_list_node_pool_top
   import lnp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [2:0]    req_mode,
   input  logic [3:0]    req_node,
   input  logic [7:0]    req_entry_slot,
   input  logic [31:0]   req_entry_tick,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [1:0]    rsp_status,
   output idx_type       rsp_touched_node,
   output idx_type       rsp_touched_next,
   output logic [7:0]    rsp_read_slot,
   output logic [31:0]   rsp_read_tick,
   output idx_type       rsp_list_head,
   output idx_type       rsp_free_head
);

   lnp_state_type state_ff, state_in;

   logic [2:0]  mode_ff, mode_in;
   addr_type    node_ff, node_in;
   logic [7:0]  slot_ff, slot_in;
   logic [31:0] tick_ff, tick_in;
   addr_type    t_ff, t_in;
   addr_type    n_ff, n_in;
   addr_type    sweep_ff, sweep_in;
   link_type    head_ff, head_in;
   link_type    free_ff, free_in;
   link_type    touched_ff, touched_in;
   logic [1:0]  status_ff, status_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   idx_type     rsp_node_ff, rsp_node_in;
   idx_type     rsp_next_ff, rsp_next_in;
   logic [7:0]  rsp_slot_ff, rsp_slot_in;
   logic [31:0] rsp_tick_ff, rsp_tick_in;
   idx_type     rsp_head_ff, rsp_head_in;
   idx_type     rsp_free_ff, rsp_free_in;

   addr_type    rd_addr;
   link_type    rd_link;
   logic [7:0]  rd_slot;
   logic [31:0] rd_tick;
   lnp_wr_type  wr;

   logic accept;
   logic node_ok;
   logic out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign node_ok   = 32'(req_node) < POOL_DEPTH;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   lnp_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_link (rd_link),
      .rd_slot (rd_slot),
      .rd_tick (rd_tick),
      .wr      (wr)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_INIT) begin
                  state_in = S_SWEEP;
               end else if (req_mode == MODE_PUSH ||
                            (req_mode == MODE_INSERT && node_ok)) begin
                  state_in = free_ff[LINK_W-1] ? S_FETCH : S_ALLOC;
               end else if (req_mode == MODE_ERASE && node_ok) begin
                  state_in = S_ER_A;
               end else begin
                  state_in = S_FETCH;
               end
            end
         end
         S_SWEEP: begin
            if (sweep_ff == ADDR_W'(POOL_DEPTH - 1)) begin
               state_in = S_SENT;
            end
         end
         S_SENT:  state_in = S_FETCH;
         S_ALLOC: state_in = (mode_ff == MODE_PUSH) ? S_FETCH : S_INS_A;
         S_INS_A: state_in = S_INS_B;
         S_INS_B: state_in = S_FETCH;
         S_ER_A:  state_in = rd_link[LINK_W-1] ? S_FETCH : S_ER_B;
         S_ER_B:  state_in = S_ER_C;
         S_ER_C:  state_in = S_FETCH;
         S_FETCH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      mode_in    = mode_ff;
      node_in    = node_ff;
      slot_in    = slot_ff;
      tick_in    = tick_ff;
      t_in       = t_ff;
      n_in       = n_ff;
      sweep_in   = sweep_ff;
      head_in    = head_ff;
      free_in    = free_ff;
      touched_in = touched_ff;
      status_in  = status_ff;
      rd_addr    = touched_ff[ADDR_W-1:0];
      wr         = '0;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_node_in   = rsp_node_ff;
      rsp_next_in   = rsp_next_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_tick_in   = rsp_tick_ff;
      rsp_head_in   = rsp_head_ff;
      rsp_free_in   = rsp_free_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in    = req_mode;
               node_in    = ADDR_W'(req_node);
               slot_in    = req_entry_slot;
               tick_in    = req_entry_tick;
               sweep_in   = '0;
               status_in  = STATUS_DONE;
               touched_in = NIL_LINK;
               if ((req_mode == MODE_PUSH || (req_mode == MODE_INSERT && node_ok)) &&
                   free_ff[LINK_W-1]) begin
                  status_in = STATUS_FULL;
               end else if (req_mode == MODE_READ && node_ok) begin
                  touched_in = LINK_W'({1'b0, ADDR_W'(req_node)});
               end
            end
         end
         S_SWEEP: begin
            wr.link_we = 1'b1;
            wr.addr    = sweep_ff;
            if (sweep_ff == ADDR_W'(POOL_DEPTH - 1)) begin
               wr.link = NIL_LINK;
            end else begin
               wr.link = LINK_W'({1'b0, sweep_ff}) + LINK_W'(1);
            end
            sweep_in = sweep_ff + ADDR_W'(1);
         end
         S_SENT: begin
            rd_addr    = '0;
            free_in    = rd_link;
            wr.link_we = 1'b1;
            wr.pay_we  = 1'b1;
            wr.addr    = '0;
            wr.link    = NIL_LINK;
            head_in    = '0;
            touched_in = '0;
         end
         S_ALLOC: begin
            rd_addr   = free_ff[ADDR_W-1:0];
            n_in      = free_ff[ADDR_W-1:0];
            free_in   = rd_link;
            wr.pay_we = 1'b1;
            wr.addr   = free_ff[ADDR_W-1:0];
            wr.slot   = slot_ff;
            wr.tick   = tick_ff;
            if (mode_ff == MODE_PUSH) begin
               wr.link_we = 1'b1;
               wr.link    = head_ff;
               head_in    = free_ff;
               touched_in = free_ff;
            end
         end
         S_INS_A: begin
            rd_addr    = node_ff;
            wr.link_we = 1'b1;
            wr.addr    = n_ff;
            wr.link    = rd_link;
         end
         S_INS_B: begin
            wr.link_we = 1'b1;
            wr.addr    = node_ff;
            wr.link    = LINK_W'({1'b0, n_ff});
            touched_in = LINK_W'({1'b0, n_ff});
         end
         S_ER_A: begin
            rd_addr = node_ff;
            t_in    = rd_link[ADDR_W-1:0];
            if (rd_link[LINK_W-1]) begin
               status_in = STATUS_NO_SUCC;
            end
         end
         S_ER_B: begin
            rd_addr    = t_ff;
            wr.link_we = 1'b1;
            wr.addr    = node_ff;
            wr.link    = rd_link;
         end
         S_ER_C: begin
            wr.link_we = 1'b1;
            wr.addr    = t_ff;
            wr.link    = free_ff;
            free_in    = LINK_W'({1'b0, t_ff});
            touched_in = LINK_W'({1'b0, t_ff});
         end
         S_FETCH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_node_in   = to_idx(touched_ff);
               rsp_head_in   = to_idx(head_ff);
               rsp_free_in   = to_idx(free_ff);
               if (touched_ff[LINK_W-1]) begin
                  rsp_next_in = to_idx(NIL_LINK);
                  rsp_slot_in = '0;
                  rsp_tick_in = '0;
               end else begin
                  rsp_next_in = to_idx(rd_link);
                  rsp_slot_in = rd_slot;
                  rsp_tick_in = rd_tick;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         free_ff      <= LINK_W'(1);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      node_ff       <= node_in;
      slot_ff       <= slot_in;
      tick_ff       <= tick_in;
      t_ff          <= t_in;
      n_ff          <= n_in;
      sweep_ff      <= sweep_in;
      touched_ff    <= touched_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_node_ff   <= rsp_node_in;
      rsp_next_ff   <= rsp_next_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_tick_ff   <= rsp_tick_in;
      rsp_head_ff   <= rsp_head_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_touched_node = rsp_node_ff;
   assign rsp_touched_next = rsp_next_ff;
   assign rsp_read_slot    = rsp_slot_ff;
   assign rsp_read_tick    = rsp_tick_ff;
   assign rsp_list_head    = rsp_head_ff;
   assign rsp_free_head    = rsp_free_ff;

endmodule

FILE: verif/lnp_checker.sv
// ----------------------------------------------------------------------------
// lnp_checker
// Scoreboard for the linked list node pool.
//
// Watches the req_ and rsp_ channels. Every accepted request transaction is
// run through a local copy of the node store, free chain and list head, and
// the predicted response is queued. Every accepted response transaction is
// compared field by field with the oldest queued prediction.
// ----------------------------------------------------------------------------
module lnp_checker
   import lnp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [3:0]  req_node,
   input  logic [7:0]  req_entry_slot,
   input  logic [31:0] req_entry_tick,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  idx_type     rsp_touched_node,
   input  idx_type     rsp_touched_next,
   input  logic [7:0]  rsp_read_slot,
   input  logic [31:0] rsp_read_tick,
   input  idx_type     rsp_list_head,
   input  idx_type     rsp_free_head,
   output int          errors,
   output int          pending,
   output int          full_seen,
   output int          no_succ_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [1:0]  status;
      idx_type     node;
      idx_type     next;
      logic [7:0]  slot;
      logic [31:0] tick;
      idx_type     list_head;
      idx_type     free_head;
   } pool_result_type;

   // shadow of the node store
   int          link_mem [POOL_DEPTH];
   logic [7:0]  slot_mem [POOL_DEPTH];
   logic [31:0] tick_mem [POOL_DEPTH];
   int          head_ptr;
   int          free_ptr;

   pool_result_type expected_q[$];
   int err_ct;
   int full_ct;
   int no_succ_ct;

   function automatic idx_type as_idx(input int v);
      return idx_type'(v);
   endfunction

   // chain every node into the free chain, then take node 0 as the sentinel
   function automatic void rebuild_chain();
      int n;
      for (int i = 0; i < POOL_DEPTH; i++)
         link_mem[i] = (i + 1 < POOL_DEPTH) ? i + 1 : -1;
      free_ptr = 0;
      head_ptr = -1;
      n = free_ptr;
      free_ptr = link_mem[n];
      slot_mem[n] = '0;
      tick_mem[n] = '0;
      link_mem[n] = head_ptr;
      head_ptr = n;
   endfunction

   function automatic pool_result_type apply_op(input logic [2:0] mode,
                                                input logic [3:0] node,
                                                input logic [7:0] slot,
                                                input logic [31:0] tick);
      pool_result_type r;
      int  n;
      int  t;
      int  touched;
      bit  node_ok;
      r.status = STATUS_DONE;
      touched  = -1;
      node_ok  = int'(node) < POOL_DEPTH;
      case (mode)
         MODE_INIT: begin
            rebuild_chain();
            touched = head_ptr;
         end
         MODE_PUSH, MODE_INSERT: begin
            if (mode == MODE_PUSH || node_ok) begin
               if (free_ptr < 0) begin
                  r.status = STATUS_FULL;
               end else begin
                  n = free_ptr;
                  free_ptr = link_mem[n];
                  slot_mem[n] = slot;
                  tick_mem[n] = tick;
                  if (mode == MODE_PUSH) begin
                     link_mem[n] = head_ptr;
                     head_ptr = n;
                  end else begin
                     link_mem[n] = link_mem[node];
                     link_mem[node] = n;
                  end
                  touched = n;
               end
            end
         end
         MODE_ERASE: begin
            if (node_ok) begin
               t = link_mem[node];
               if (t < 0) begin
                  r.status = STATUS_NO_SUCC;
               end else begin
                  link_mem[node] = link_mem[t];
                  link_mem[t] = free_ptr;
                  free_ptr = t;
                  touched = t;
               end
            end
         end
         MODE_READ: begin
            if (node_ok)
               touched = node;
         end
         default: ;
      endcase
      r.node = as_idx(touched);
      if (touched >= 0 && touched < POOL_DEPTH) begin
         r.next = as_idx(link_mem[touched]);
         r.slot = slot_mem[touched];
         r.tick = tick_mem[touched];
      end else begin
         r.next = as_idx(-1);
         r.slot = '0;
         r.tick = '0;
      end
      r.list_head = as_idx(head_ptr);
      r.free_head = as_idx(free_ptr);
      return r;
   endfunction

   always @(posedge clock) begin
      pool_result_type exp_r;
      pool_result_type act_r;
      if (reset) begin
         for (int i = 0; i < POOL_DEPTH; i++) begin
            slot_mem[i] = '0;
            tick_mem[i] = '0;
         end
         rebuild_chain();
         expected_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            act_r.status    = rsp_status;
            act_r.node      = rsp_touched_node;
            act_r.next      = rsp_touched_next;
            act_r.slot      = rsp_read_slot;
            act_r.tick      = rsp_read_tick;
            act_r.list_head = rsp_list_head;
            act_r.free_head = rsp_free_head;
            if (act_r.status == STATUS_FULL)
               full_ct++;
            if (act_r.status == STATUS_NO_SUCC)
               no_succ_ct++;
            if (expected_q.size() == 0) begin
               err_ct++;
               if (err_ct <= MAX_REPORTS)
                  $display("%0t: unexpected response transaction: st=%0d node=%0d",
                           $realtime, act_r.status, act_r.node);
            end else begin
               exp_r = expected_q.pop_front();
               if (act_r.status    !== exp_r.status    || act_r.node      !== exp_r.node ||
                   act_r.next      !== exp_r.next      || act_r.slot      !== exp_r.slot ||
                   act_r.tick      !== exp_r.tick      ||
                   act_r.list_head !== exp_r.list_head ||
                   act_r.free_head !== exp_r.free_head) begin
                  err_ct++;
                  if (err_ct <= MAX_REPORTS) begin
                     $display("%0t: mismatch exp st=%0d node=%0d next=%0d slot=%h tick=%h head=%0d free=%0d",
                              $realtime, exp_r.status, exp_r.node, exp_r.next, exp_r.slot,
                              exp_r.tick, exp_r.list_head, exp_r.free_head);
                     $display("%0t:          got st=%0d node=%0d next=%0d slot=%h tick=%h head=%0d free=%0d",
                              $realtime, act_r.status, act_r.node, act_r.next, act_r.slot,
                              act_r.tick, act_r.list_head, act_r.free_head);
                  end
               end
            end
         end
         if (req_valid && req_ready)
            expected_q.push_back(apply_op(req_mode, req_node, req_entry_slot,
                                          req_entry_tick));
      end
      errors       <= err_ct;
      pending      <= expected_q.size();
      full_seen    <= full_ct;
      no_succ_seen <= no_succ_ct;
   end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the linked list node pool.
//
// A short directed run walks the read, push, insert, erase and reinitialise
// operations, unused mode codes and the no-successor case. Random traffic
// follows in blocks: fill runs that drive the pool to full, drain runs of
// erases, and mixed single operations. Both sides idle at random, with one
// calm window and one long response hold-off that backs the pool up. The
// lnp_checker instance predicts and compares every response transaction.
// ----------------------------------------------------------------------------
module testbench;
   import lnp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          N_ITEMS          = 700;
   localparam int          IDLE_PCT         = 30;
   localparam int          CALM_FROM        = 450;
   localparam int          CALM_TO          = 560;
   localparam int          HOLD_AT          = 300;
   localparam int          HOLD_CYCLES      = 300;
   localparam int          WATCHDOG_LIMIT   = 2000;
   localparam int          DRAIN_CYCLES     = POOL_DEPTH + 8;
   localparam logic [2:0]  MODE_SPARE_FIRST = 3'd5;
   localparam logic [2:0]  MODE_SPARE_LAST  = 3'd7;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_mode;
   logic [3:0]  req_node;
   logic [7:0]  req_entry_slot;
   logic [31:0] req_entry_tick;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   idx_type     rsp_touched_node;
   idx_type     rsp_touched_next;
   logic [7:0]  rsp_read_slot;
   logic [31:0] rsp_read_tick;
   idx_type     rsp_list_head;
   idx_type     rsp_free_head;

   int errors;
   int pending;
   int full_seen;
   int no_succ_seen;
   int sent_count;
   int mode_count [8];
   int hold_left;
   bit hold_done;
   int quiet_cycles;

   wire calm = (sent_count >= CALM_FROM) && (sent_count < CALM_TO);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   linked_list_node_pool_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_node         (req_node),
      .req_entry_slot   (req_entry_slot),
      .req_entry_tick   (req_entry_tick),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_touched_node (rsp_touched_node),
      .rsp_touched_next (rsp_touched_next),
      .rsp_read_slot    (rsp_read_slot),
      .rsp_read_tick    (rsp_read_tick),
      .rsp_list_head    (rsp_list_head),
      .rsp_free_head    (rsp_free_head)
   );

   lnp_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_node         (req_node),
      .req_entry_slot   (req_entry_slot),
      .req_entry_tick   (req_entry_tick),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_touched_node (rsp_touched_node),
      .rsp_touched_next (rsp_touched_next),
      .rsp_read_slot    (rsp_read_slot),
      .rsp_read_tick    (rsp_read_tick),
      .rsp_list_head    (rsp_list_head),
      .rsp_free_head    (rsp_free_head),
      .errors           (errors),
      .pending          (pending),
      .full_seen        (full_seen),
      .no_succ_seen     (no_succ_seen)
   );

   // response side: random stalls, a calm window, one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && sent_count >= HOLD_AT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // watchdog: cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("testbench: errors");
            $finish;
         end
      end
   end

   task automatic send_op(input logic [2:0] mode, input logic [3:0] node,
                          input logic [7:0] slot, input logic [31:0] tick);
      if (!calm) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_node       <= node;
      req_entry_slot <= slot;
      req_entry_tick <= tick;
      do
         @(posedge clock);
      while (!req_ready);
      sent_count++;
      mode_count[mode]++;
   endtask

   task automatic send_rand(input logic [2:0] mode, input logic [3:0] node);
      send_op(mode, node, 8'($urandom_range(0, 255)), $urandom());
   endtask

   initial begin
      int pick;
      int len;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_mode       <= MODE_READ;
      req_node       <= '0;
      req_entry_slot <= '0;
      req_entry_tick <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      send_op(MODE_READ,   4'd0,  8'h00, 32'h0);
      send_op(MODE_READ,   4'd15, 8'h00, 32'h0);
      send_op(MODE_PUSH,   4'd0,  8'h00, 32'h0000_0000);
      send_op(MODE_PUSH,   4'd15, 8'hff, 32'hffff_ffff);
      send_op(MODE_INSERT, 4'd15, 8'ha5, 32'h5a5a_a5a5);
      send_op(MODE_INSERT, 4'd0,  8'h5a, 32'ha5a5_5a5a);
      send_op(MODE_ERASE,  4'd0,  8'h11, 32'h1111_1111);
      send_op(MODE_ERASE,  4'd15, 8'h22, 32'h2222_2222);
      send_op(MODE_ERASE,  4'd15, 8'h33, 32'h3333_3333);
      send_op(MODE_READ,   4'd1,  8'h00, 32'h0);
      for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
         send_rand(3'(m), 4'($urandom_range(0, 15)));
      send_op(MODE_INIT,   4'd9,  8'hff, 32'hffff_ffff);
      send_op(MODE_ERASE,  4'd0,  8'h00, 32'h0);
      send_op(MODE_READ,   4'd0,  8'h00, 32'h0);
      send_op(MODE_READ,   4'd2,  8'h00, 32'h0);

      // fill from a fresh pool until it reports full
      send_rand(MODE_INIT, 4'($urandom_range(0, 15)));
      repeat (POOL_DEPTH) send_rand(MODE_PUSH, 4'($urandom_range(0, 15)));
      send_rand(MODE_INSERT, 4'($urandom_range(0, 15)));

      // random blocks
      while (sent_count < N_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            len = $urandom_range(12, 20);
            repeat (len)
               send_rand($urandom_range(0, 1) ? MODE_PUSH : MODE_INSERT,
                         4'($urandom_range(0, 15)));
         end else if (pick < 28) begin
            len = $urandom_range(8, 16);
            repeat (len)
               send_rand(MODE_ERASE, $urandom_range(0, 1) ? 4'($urandom_range(0, 3))
                                                          : 4'($urandom_range(0, 15)));
         end else if (pick < 31) begin
            send_rand(MODE_INIT, 4'($urandom_range(0, 15)));
         end else if (pick < 33) begin
            send_rand(3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)),
                      4'($urandom_range(0, 15)));
         end else begin
            case ($urandom_range(0, 3))
               0:       send_rand(MODE_PUSH,   4'($urandom_range(0, 15)));
               1:       send_rand(MODE_INSERT, 4'($urandom_range(0, 15)));
               2:       send_rand(MODE_ERASE,  4'($urandom_range(0, 15)));
               default: send_rand(MODE_READ,   4'($urandom_range(0, 15)));
            endcase
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests: %0d reinit, %0d push, %0d insert, %0d erase, %0d read",
               sent_count, mode_count[MODE_INIT], mode_count[MODE_PUSH],
               mode_count[MODE_INSERT], mode_count[MODE_ERASE], mode_count[MODE_READ]);
      $display("pool-full seen %0d, no-successor seen %0d, mismatches %0d, left over %0d",
               full_seen, no_succ_seen, errors, pending);
      if (errors == 0 && pending == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

FILE: sim.f
sv/lnp_pkg.sv
sv/lnp_store.sv
sv/linked_list_node_pool_top.sv
verif/lnp_checker.sv
verif/testbench.sv
